// ----- rtl/pfde_pkg.sv -----
package pfde_pkg;

  // Letter codes, A is zero.
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_Q = 5'd16;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_Z = 5'd25;

  // Square geometry.
  localparam int unsigned SIDE     = 5;
  localparam int unsigned ALPHABET = 26;
  localparam logic [4:0]  CELLS    = 5'd25;

  // Every letter of the alphabet is in use once the square is complete.
  localparam logic [ALPHABET-1:0] ALL_USED = {ALPHABET{1'b1}};

  // Kinds of word passed from the front end to the back end.
  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_PAIR = 1'b1
  } cmd_kind_t;

  // For a key word, a is the letter and last marks the final key letter.
  // For a pair word, a and b are the plain letters and last is the result flag.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] a;
    logic [4:0] b;
    logic       last;
  } cmd_t;

  // One enciphered pair.
  typedef struct packed {
    logic [4:0] cipher_first;
    logic [4:0] cipher_second;
    logic       last;
  } res_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_FILL,
    B_POS,
    B_CELL
  } back_state_t;

  // Row of a cell number 0..24.
  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    priority if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15)     r = 3'd3;
    else if (p >= 5'd10)     r = 3'd2;
    else if (p >= 5'd5)      r = 3'd1;
    else                     r = 3'd0;
    return r;
  endfunction

  // Cell number from row and column.
  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  // Column of a cell number 0..24.
  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] t;
    t = p - cell_index(pos_row(p), 3'd0);
    return t[2:0];
  endfunction

  // Step one row or column on, wrapping at the edge of the square.
  function automatic logic [2:0] wrap_inc(input logic [2:0] x);
    return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
  endfunction

endpackage

// ----- rtl/pfde_fifo.sv -----
module pfde_fifo #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  // Handshake qualification.
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // Pointer and count updates, pointers wrap at the depth.
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/pfde_front.sv -----
module pfde_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  logic           in_mode,
  input  logic [4:0]     in_letter,
  input  logic           in_final_item,
  input  logic           cmd_full,
  output logic           cmd_push,
  output pfde_pkg::cmd_t cmd_data
);
  import pfde_pkg::*;

  logic       ready_r, ready_nxt;
  logic       pend_v_r, pend_v_nxt;
  logic [4:0] pend_l_r, pend_l_nxt;
  logic       hold_r, hold_nxt;
  logic [4:0] hold_l_r, hold_l_nxt;
  logic [4:0] c;
  logic       accept;

  // A doubled final letter owes a second pair and blocks input for it.
  assign in_full = cmd_full || hold_r;
  assign accept  = in_push && !in_full;
  assign c       = (in_letter > LETTER_Z) ? LETTER_Z : in_letter;

  // Classify each word and turn it into key or pair words for the back end.
  always_comb begin
    ready_nxt  = ready_r;
    pend_v_nxt = pend_v_r;
    pend_l_nxt = pend_l_r;
    hold_nxt   = hold_r;
    hold_l_nxt = hold_l_r;
    cmd_push   = 1'b0;
    cmd_data   = '{kind: CMD_PAIR, a: c, b: LETTER_X, last: 1'b1};
    if (hold_r) begin
      if (!cmd_full) begin
        cmd_push = 1'b1;
        cmd_data = '{kind: CMD_PAIR, a: hold_l_r, b: LETTER_X, last: 1'b1};
        hold_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!in_mode) begin
        // Key letters are dropped once the square is complete.
        if (!ready_r) begin
          cmd_push = 1'b1;
          cmd_data = '{kind: CMD_KEY, a: c, b: c, last: in_final_item};
          if (in_final_item) begin
            ready_nxt = 1'b1;
          end
        end
      end else if (ready_r) begin
        if (!pend_v_r) begin
          if (in_final_item) begin
            cmd_push = 1'b1;
          end else begin
            pend_v_nxt = 1'b1;
            pend_l_nxt = c;
          end
        end else if (pend_l_r != c) begin
          cmd_push   = 1'b1;
          cmd_data   = '{kind: CMD_PAIR, a: pend_l_r, b: c, last: 1'b1};
          pend_v_nxt = 1'b0;
        end else begin
          // Doubled letter: pad the waiting one, the new one opens a pair.
          cmd_push = 1'b1;
          cmd_data = '{kind: CMD_PAIR, a: pend_l_r,
                       b: (c == LETTER_X) ? LETTER_Q : LETTER_X,
                       last: !in_final_item};
          if (in_final_item) begin
            pend_v_nxt = 1'b0;
            hold_nxt   = 1'b1;
            hold_l_nxt = c;
          end else begin
            pend_l_nxt = c;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r  <= 1'b0;
      pend_v_r <= 1'b0;
      pend_l_r <= '0;
      hold_r   <= 1'b0;
    end else begin
      ready_r  <= ready_nxt;
      pend_v_r <= pend_v_nxt;
      pend_l_r <= pend_l_nxt;
      hold_r   <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_l_r <= hold_l_nxt;
  end

endmodule

// ----- rtl/pfde_back.sv -----
module pfde_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_empty,
  input  pfde_pkg::cmd_t cmd_data,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output pfde_pkg::res_t res_data
);
  import pfde_pkg::*;

  back_state_t         state_r, state_nxt;
  logic [ALPHABET-1:0] used_r;
  logic [4:0]          cells_r;
  logic [4:0]          fill_i_r;
  logic                last_r;

  // Letter position and square contents, both read at two addresses.
  logic [4:0] pos_mem [ALPHABET];
  logic [4:0] cell_mem [CELLS];
  logic [4:0] pos_a_q, pos_b_q;
  logic [4:0] cell_a_q, cell_b_q;

  logic       place_req, place_en;
  logic [4:0] place_c;
  logic       pos_rd, cell_rd;
  logic [2:0] ra, ca, rb, cb;
  logic [4:0] ea, eb;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_data.kind == CMD_PAIR) begin
            state_nxt = B_POS;
          end else if (cmd_data.last) begin
            state_nxt = B_FILL;
          end
        end
      end
      B_FILL: begin
        if (fill_i_r == LETTER_Z) begin
          state_nxt = B_IDLE;
        end
      end
      B_POS: state_nxt = B_CELL;
      B_CELL: begin
        if (!res_full) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control outputs per state.
  always_comb begin
    cmd_pop   = 1'b0;
    place_req = 1'b0;
    place_c   = cmd_data.a;
    pos_rd    = 1'b0;
    cell_rd   = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        cmd_pop = !cmd_empty;
        if (!cmd_empty) begin
          place_req = (cmd_data.kind == CMD_KEY);
          pos_rd    = (cmd_data.kind == CMD_PAIR);
        end
      end
      B_FILL: begin
        place_req = 1'b1;
        place_c   = fill_i_r;
      end
      B_POS:  cell_rd  = 1'b1;
      B_CELL: res_push = !res_full;
      default: ;
    endcase
  end

  // A letter takes the next cell unless it is used or the square is full.
  assign place_en = place_req && !used_r[place_c] && (cells_r < CELLS);

  // Encipher from the registered positions.
  always_comb begin
    ra = pos_row(pos_a_q);
    ca = pos_col(pos_a_q);
    rb = pos_row(pos_b_q);
    cb = pos_col(pos_b_q);
    priority if (ra == rb) begin
      ea = cell_index(ra, wrap_inc(ca));
      eb = cell_index(rb, wrap_inc(cb));
    end else if (ca == cb) begin
      ea = cell_index(wrap_inc(ra), ca);
      eb = cell_index(wrap_inc(rb), cb);
    end else begin
      ea = cell_index(ra, cb);
      eb = cell_index(rb, ca);
    end
  end

  assign res_data = '{cipher_first: cell_a_q, cipher_second: cell_b_q, last: last_r};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      used_r   <= ALPHABET'(1) << LETTER_J;
      cells_r  <= '0;
      fill_i_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (place_en) begin
        used_r[place_c] <= 1'b1;
        cells_r         <= cells_r + 5'd1;
      end
      if (state_r == B_FILL) begin
        fill_i_r <= fill_i_r + 5'd1;
      end else begin
        fill_i_r <= '0;
      end
    end
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (place_en) begin
      cell_mem[cells_r] <= place_c;
      pos_mem[place_c]  <= cells_r;
    end
    if (pos_rd) begin
      pos_a_q <= pos_mem[cmd_data.a];
      pos_b_q <= pos_mem[cmd_data.b];
      last_r  <= cmd_data.last;
    end
    if (cell_rd) begin
      cell_a_q <= cell_mem[ea];
      cell_b_q <= cell_mem[eb];
    end
  end

`ifndef SYNTHESIS
  // The fill sweep always leaves a complete square.
  a_fill_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FILL && fill_i_r == LETTER_Z) |=> (cells_r == CELLS))
    else $error("square incomplete after fill");

  // No pair is enciphered before every letter has a cell.
  a_pair_after_square: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_POS) |-> (used_r == ALL_USED))
    else $error("pair enciphered before square ready");

  // Placing a letter marks it used and takes exactly one cell.
  a_place_once: assert property (@(posedge clk) disable iff (!rst_n)
    place_en |=> (used_r[$past(place_c)] && cells_r == $past(cells_r) + 5'd1))
    else $error("letter placement bookkeeping wrong");
`endif

endmodule

// ----- rtl/playfair_digraph_encrypt.sv -----
// Channel  Ports                                         Handshake
// input    in_mode, in_letter, in_final_item             in_push / in_full
// result   out_cipher_first, out_cipher_second,          out_pop / out_empty
//          out_last_of_run
//
// The front end takes one word per cycle while its command queue has room and no padded pair is owed.
// A key letter is placed as it is popped; the final key letter starts a
// sweep that places the remaining letters into the square.
// Each enciphered pair passes through position read, cell read and result, which waits on a full result queue.
// A doubled final message letter holds in_full high until its second pair is pushed.
// Reset is synchronous; the square is empty and all queues are cleared.
module playfair_digraph_encrypt #(
  parameter int unsigned CMDQ_DEPTH = 4,
  parameter int unsigned OUTQ_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_mode,
  input  logic [4:0] in_letter,
  input  logic       in_final_item,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [4:0] out_cipher_first,
  output logic [4:0] out_cipher_second,
  output logic       out_last_of_run
);
  import pfde_pkg::*;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  res_t res_in, res_out;
  logic res_push, res_full;

  // Front end: pairing and classification.
  pfde_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_mode       (in_mode),
    .in_letter     (in_letter),
    .in_final_item (in_final_item),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in)
  );

  // Command queue between the two halves.
  pfde_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Back end: square building and enciphering.
  pfde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // Result queue facing the consumer.
  pfde_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_cipher_first  = res_out.cipher_first;
  assign out_cipher_second = res_out.cipher_second;
  assign out_last_of_run   = res_out.last;

endmodule

// ----- dv/tb_playfair_digraph_encrypt.sv -----
module tb_playfair_digraph_encrypt;
  timeunit 1ns;
  timeprecision 1ps;

  import pfde_pkg::*;

  // Values of the mode field.
  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_MSG = 1'b1;

  // Letter codes not given by the package, and raw values above Z.
  localparam logic [4:0] LETTER_A       = 5'd0;
  localparam logic [4:0] LETTER_ABOVE_Z = 5'd26;
  localparam logic [4:0] LETTER_TOP     = 5'd31;

  // Cycles with no word moving on either side before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 3000;
  // Length of the long receiver hold-off.
  localparam int unsigned HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic       in_mode = MODE_KEY;
  logic [4:0] in_letter = LETTER_A;
  logic       in_final_item = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [4:0] out_cipher_first;
  logic [4:0] out_cipher_second;
  logic       out_last_of_run;

  playfair_digraph_encrypt dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_mode          (in_mode),
    .in_letter        (in_letter),
    .in_final_item    (in_final_item),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_cipher_first (out_cipher_first),
    .out_cipher_second(out_cipher_second),
    .out_last_of_run  (out_last_of_run)
  );

  always #1 clk = ~clk;

  // Shadow copy of the square and of the pairing state.
  logic [ALPHABET-1:0] sq_used;
  logic [4:0]          sq_pos [ALPHABET];
  logic [4:0]          sq_cell [SIDE*SIDE];
  int unsigned         sq_count;
  bit                  sq_ready;
  bit                  pair_open;
  logic [4:0]          pair_first;

  // Enciphered pairs that the block still owes, oldest first.
  res_t pairs_due [$];

  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold = 0;
  int unsigned quiet_cycles = 0;
  res_t        want;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Append one pair to the owed list.
  function automatic void owe_pair(input res_t r);
    pairs_due = {pairs_due, r};
  endfunction

  function automatic void square_clear();
    sq_used = '0;
    sq_used[LETTER_J] = 1'b1;
    foreach (sq_pos[i]) sq_pos[i] = '0;
    foreach (sq_cell[i]) sq_cell[i] = '0;
    sq_count = 0;
    sq_ready = 1'b0;
    pair_open = 1'b0;
    pair_first = '0;
  endfunction

  // Put a letter into the next free cell unless it is already placed.
  function automatic void place_letter(input logic [4:0] c);
    if (sq_used[c] || sq_count >= SIDE * SIDE) return;
    sq_used[c] = 1'b1;
    sq_cell[sq_count] = c;
    sq_pos[c] = 5'(sq_count);
    sq_count++;
  endfunction

  // Row rule, column rule, or rectangle swap, all wrapping at the edge.
  function automatic res_t encipher_pair(input logic [4:0] a, input logic [4:0] b,
                                         input logic last);
    int unsigned pa, pb, ra, ca, rb, cb, ea, eb;
    res_t r;
    pa = sq_pos[a] % (SIDE * SIDE);
    pb = sq_pos[b] % (SIDE * SIDE);
    ra = pa / SIDE;
    ca = pa % SIDE;
    rb = pb / SIDE;
    cb = pb % SIDE;
    if (ra == rb) begin
      ea = ra * SIDE + (ca + 1) % SIDE;
      eb = rb * SIDE + (cb + 1) % SIDE;
    end else if (ca == cb) begin
      ea = ((ra + 1) % SIDE) * SIDE + ca;
      eb = ((rb + 1) % SIDE) * SIDE + cb;
    end else begin
      ea = ra * SIDE + cb;
      eb = rb * SIDE + ca;
    end
    r.cipher_first = sq_cell[ea];
    r.cipher_second = sq_cell[eb];
    r.last = last;
    return r;
  endfunction

  // Work out the pairs caused by one accepted word.
  function automatic void playfair_predict(input logic m, input logic [4:0] raw,
                                           input logic fin);
    logic [4:0] c;
    c = (raw > LETTER_Z) ? LETTER_Z : raw;
    if (m == MODE_KEY) begin
      if (!sq_ready) begin
        place_letter(c);
        if (fin) begin
          for (int i = 0; i < ALPHABET; i++) place_letter(5'(i));
          sq_ready = 1'b1;
        end
      end
    end else if (sq_ready) begin
      if (!pair_open) begin
        if (fin) begin
          owe_pair(encipher_pair(c, LETTER_X, 1'b1));
        end else begin
          pair_open = 1'b1;
          pair_first = c;
        end
      end else if (pair_first != c) begin
        owe_pair(encipher_pair(pair_first, c, 1'b1));
        pair_open = 1'b0;
      end else begin
        // A doubled letter is split by a pad and then opens the next pair.
        owe_pair(encipher_pair(pair_first,
                               (c == LETTER_X) ? LETTER_Q : LETTER_X, !fin));
        if (fin) begin
          owe_pair(encipher_pair(c, LETTER_X, 1'b1));
          pair_open = 1'b0;
        end else begin
          pair_first = c;
        end
      end
    end
  endfunction

  // Offer one word, with random gaps ahead of it, and hold it until taken.
  task automatic send_word(input logic m, input logic [4:0] l, input logic f);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      in_mode = 1'($urandom_range(1));
      in_letter = 5'($urandom_range(31));
      in_final_item = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_mode = m;
    in_letter = l;
    in_final_item = f;
    in_push = 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    playfair_predict(m, l, f);
  endtask

  // Stop offering words and wait for every owed pair to be taken.
  task automatic drain_pairs();
    @(negedge clk);
    in_push = 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_plain();
    logic [4:0] l;
    do l = 5'($urandom_range(31)); while (l == LETTER_J);
    return l;
  endfunction

  // Message letters sent before any key must be dropped.
  task automatic test_text_before_key();
    send_word(MODE_MSG, LETTER_A, 1'b0);
    send_word(MODE_MSG, LETTER_TOP, 1'b1);
    send_word(MODE_MSG, LETTER_X, 1'b0);
  endtask

  // Key with a clamped letter, a J, a repeat and a final mark on a repeat.
  task automatic test_key_build();
    int unsigned extra;
    send_word(MODE_KEY, LETTER_TOP, 1'b0);
    send_word(MODE_KEY, LETTER_J, 1'b0);
    send_word(MODE_KEY, LETTER_A, 1'b0);
    send_word(MODE_KEY, LETTER_A, 1'b0);
    send_word(MODE_KEY, LETTER_X, 1'b0);
    extra = $urandom_range(8);
    repeat (extra) send_word(MODE_KEY, 5'($urandom_range(31)), 1'b0);
    send_word(MODE_KEY, LETTER_A, 1'b1);
  endtask

  // Key letters after the square is complete change nothing.
  task automatic test_key_after_square();
    send_word(MODE_KEY, 5'($urandom_range(31)), 1'b0);
    send_word(MODE_KEY, 5'($urandom_range(31)), 1'b1);
  endtask

  task automatic test_directed_text();
    // Same row, including the right edge.
    send_word(MODE_MSG, sq_cell[0], 1'b0);
    send_word(MODE_MSG, sq_cell[1], 1'b0);
    send_word(MODE_MSG, sq_cell[3], 1'b0);
    send_word(MODE_MSG, sq_cell[4], 1'b0);
    // Same column, including the bottom edge.
    send_word(MODE_MSG, sq_cell[2], 1'b0);
    send_word(MODE_MSG, sq_cell[7], 1'b0);
    send_word(MODE_MSG, sq_cell[4], 1'b0);
    send_word(MODE_MSG, sq_cell[24], 1'b0);
    // Rectangle.
    send_word(MODE_MSG, sq_cell[0], 1'b0);
    send_word(MODE_MSG, sq_cell[18], 1'b0);
    // A doubled letter is padded with X.
    send_word(MODE_MSG, sq_cell[5], 1'b0);
    send_word(MODE_MSG, sq_cell[5], 1'b0);
    send_word(MODE_MSG, sq_cell[6], 1'b0);
    // A doubled X is padded with Q.
    send_word(MODE_MSG, LETTER_X, 1'b0);
    send_word(MODE_MSG, LETTER_X, 1'b0);
    send_word(MODE_MSG, LETTER_A, 1'b0);
    // Lone final letters, one above Z and one X that pairs with itself.
    send_word(MODE_MSG, LETTER_TOP, 1'b1);
    send_word(MODE_MSG, LETTER_X, 1'b1);
    // A doubled final letter yields two pairs.
    send_word(MODE_MSG, sq_cell[12], 1'b0);
    send_word(MODE_MSG, sq_cell[12], 1'b1);
    send_word(MODE_MSG, LETTER_X, 1'b0);
    send_word(MODE_MSG, LETTER_X, 1'b1);
    // Final letter closing an open pair, given above Z.
    send_word(MODE_MSG, LETTER_A, 1'b0);
    send_word(MODE_MSG, LETTER_ABOVE_Z, 1'b1);
  endtask

  // Random text with frequent doubled letters and final marks, plus stray key words.
  task automatic test_random_text(input int unsigned n_letters, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned sent;
    logic [4:0]  prev;
    logic [4:0]  l;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    prev = LETTER_A;
    while (sent < n_letters) begin
      if ($urandom_range(99) < 4) begin
        send_word(MODE_KEY, 5'($urandom_range(31)), 1'($urandom_range(1)));
      end else begin
        l = (sent != 0 && $urandom_range(99) < 20) ? prev : pick_plain();
        send_word(MODE_MSG, l, 1'($urandom_range(99) < 12));
        prev = l;
        sent++;
      end
    end
  endtask

  // Hold the receiver off so the block fills, then drain before going on.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = HOLD_CYCLES;
    repeat (60) send_word(MODE_MSG, pick_plain(), 1'($urandom_range(99) < 10));
    drain_pairs();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (recv_hold != 0) begin
        out_pop = 1'b0;
        recv_hold--;
      end else begin
        out_pop = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each taken pair with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pairs_due.size() == 0) begin
        report_mismatch($sformatf("pair %0d,%0d with nothing owed",
                                  out_cipher_first, out_cipher_second));
      end else begin
        want = pairs_due.pop_front();
        if (out_cipher_first !== want.cipher_first)
          report_mismatch($sformatf("cipher_first %0d, expected %0d",
                                    out_cipher_first, want.cipher_first));
        if (out_cipher_second !== want.cipher_second)
          report_mismatch($sformatf("cipher_second %0d, expected %0d",
                                    out_cipher_second, want.cipher_second));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                    out_last_of_run, want.last));
      end
    end
  end

  // Give up when no word has moved on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_playfair_digraph_encrypt: errors");
        $finish;
      end
    end
  end

  initial begin
    square_clear();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_text_before_key();
    test_key_build();
    test_key_after_square();
    test_directed_text();
    drain_pairs();

    test_random_text(330, 0, 0);
    test_random_text(330, 77, 0);
    test_random_text(330, 0, 77);
    test_random_text(330, 30, 30);
    test_backpressure();

    recv_stall_pct = 0;
    drain_pairs();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_playfair_digraph_encrypt: clean");
    end else begin
      $display("tb_playfair_digraph_encrypt: errors");
    end
    $finish;
  end

endmodule
